[design/quaternion_slerp_defines.svh]
// ----------------------------------------------------------------------------
// quaternion_slerp_defines.svh
// Assertion macros shared by the quaternion interpolator.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_SLERP_DEFINES_SVH
`define QUATERNION_SLERP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define QS_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quaternion_slerp: implication check failed");
// next-cycle implication
`define QS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quaternion_slerp: next-cycle check failed");
`else
`define QS_ASSERT_IMPLY(label, ante, cons)
`define QS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/qs_pkg.sv]
// ----------------------------------------------------------------------------
// qs_pkg
// Constants, tables, types and helpers of the quaternion interpolator.
// ----------------------------------------------------------------------------
package qs_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int SQRT_STEPS   = 31;
	localparam int DIV_STEPS    = 48;
	localparam int KSPLIT       = 24;
	localparam int QBITS        = 30;

	localparam logic [30:0] ONE_Q30         = 31'h4000_0000;
	localparam logic [30:0] THETA_EPS       = 31'd10737;
	localparam logic [30:0] CORDIC_GAIN_INV = 31'd652032874;

	// atan(2^-i), Q30
	localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
		30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
		30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
		30'd32,        30'd16,        30'd8,         30'd4,         30'd2
	};

	typedef struct packed {
		logic [3:0][16:0] a;
		logic [3:0][15:0] b;
		logic [30:0]      t;
		logic             c_full;
	} side1_t;

	typedef struct packed {
		logic [3:0][16:0] a;
		logic [3:0][15:0] b;
		logic             pass;
	} side2_t;

	function automatic logic [15:0] sat16(input logic signed [35:0] v);
		if (v > 36'sd32767)
			return 16'h7fff;
		if (v < -36'sd32768)
			return 16'h8000;
		return v[15:0];
	endfunction

endpackage

[design/quaternion_slerp.sv]
// ----------------------------------------------------------------------------
// quaternion_slerp
// Throughput: one word per cycle, sustained while the output is taken.
// Depth is set by the 31-stage root, two 30-stage CORDIC chains and the
// 48-stage divider, all fully pipelined. A stalled output holds every stage.
// Reset (arst_n low, asynchronous) clears only the stage valid bits.
// ----------------------------------------------------------------------------
`include "quaternion_slerp_defines.svh"

module quaternion_slerp #(
	parameter int FRAC_BITS = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, fraction (16 bits each)
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_w, out_x, out_y, out_z (16 bits each)
	output logic [63:0]  m_tdata
);

	localparam int SQ  = qs_pkg::SQRT_STEPS;
	localparam int CS  = qs_pkg::CORDIC_STEPS;
	localparam int DS  = qs_pkg::DIV_STEPS;
	localparam int KS  = qs_pkg::KSPLIT;
	localparam int NSTAGE = 8 + SQ + 2 * CS + DS;
	// dot product Q(2*FRAC_BITS) to Q30
	localparam int SHR = (2 * FRAC_BITS >= 30) ? (2 * FRAC_BITS - 30) : 0;
	localparam int SHL = (2 * FRAC_BITS >= 30) ? 0 : (30 - 2 * FRAC_BITS);
	localparam int TSH = 30 - FRAC_BITS;

	// ---------------------------------------------------------------- control
	// Whole pipe advances together; it only holds when the output word waits.
	logic              en;
	logic [NSTAGE-1:0] vld_s;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[NSTAGE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTAGE-2:0], s_tvalid};
		end
	end

	// ---------------------------------------------------------------- s1: products
	logic signed [15:0] a_s1 [4];
	logic signed [15:0] b_s1 [4];
	logic signed [31:0] p_s1 [4];
	logic        [15:0] frac_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				a_s1[i] <= signed'(s_tdata[16*i +: 16]);
				b_s1[i] <= signed'(s_tdata[64 + 16*i +: 16]);
				p_s1[i] <= signed'(s_tdata[16*i +: 16]) * signed'(s_tdata[64 + 16*i +: 16]);
			end
			frac_s1 <= s_tdata[143:128];
		end
	end

	// ---------------------------------------------------------------- s2: dot, sign fold
	logic signed [33:0] dot;
	logic               neg;
	logic        [32:0] mag;
	logic        [47:0] cw;
	logic        [31:0] frac_w, one_t, frac_c;
	logic        [46:0] tw;

	logic signed [16:0] a_s2 [4];
	logic signed [15:0] b_s2 [4];
	logic        [30:0] c_s2, t_s2;

	always_comb begin
		dot = '0;
		for (int i = 0; i < 4; i++)
			dot = dot + 34'(p_s1[i]);
		neg    = dot < 0;
		mag    = neg ? 33'(-dot) : 33'(dot);
		cw     = ({15'b0, mag} << SHL) >> SHR;
		frac_w = {16'b0, frac_s1};
		one_t  = 32'd1 << FRAC_BITS;
		frac_c = (frac_w > one_t) ? one_t : frac_w;
		tw     = {15'b0, frac_c} << TSH;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				// a full-scale negative component folds to +1.0 here
				a_s2[i] <= neg ? -17'(a_s1[i]) : 17'(a_s1[i]);
				b_s2[i] <= b_s1[i];
			end
			c_s2 <= (cw > {17'b0, qs_pkg::ONE_Q30}) ? qs_pkg::ONE_Q30 : cw[30:0];
			t_s2 <= tw[30:0];
		end
	end

	// ---------------------------------------------------------------- s3: 1 - c^2
	logic [61:0]          csq;
	logic [60:0]          arg_s3;
	logic [30:0]          c_s3;
	qs_pkg::side1_t       sd1_s3;

	assign csq = c_s2 * c_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s3 <= (61'd1 << 60) - csq[60:0];
			c_s3   <= c_s2;
			for (int i = 0; i < 4; i++) begin
				sd1_s3.a[i] <= a_s2[i];
				sd1_s3.b[i] <= b_s2[i];
			end
			sd1_s3.t      <= t_s2;
			sd1_s3.c_full <= (c_s2 == qs_pkg::ONE_Q30);
		end
	end

	// ---------------------------------------------------------------- root and angle
	logic        [30:0] root, c_dly;
	logic signed [33:0] ang;
	qs_pkg::side1_t     sd1_dly;

	qs_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.v    (arg_s3),
		.root (root)
	);

	qs_delay #(.W(31), .N(SQ)) u_c_dly (
		.clk  (clk),
		.en   (en),
		.din  (c_s3),
		.dout (c_dly)
	);

	qs_cordic_vec u_acos (
		.clk (clk),
		.en  (en),
		.x0  (c_dly),
		.y0  (root),
		.ang (ang)
	);

	qs_delay #(.W($bits(qs_pkg::side1_t)), .N(SQ + CS)) u_sd1_dly (
		.clk  (clk),
		.en   (en),
		.din  (sd1_s3),
		.dout (sd1_dly)
	);

	// ---------------------------------------------------------------- s4: split angles
	logic [30:0]    theta_c;
	logic [61:0]    pr1, pr2;
	logic [30:0]    theta_s4, ang1_s4, ang2_s4;
	qs_pkg::side2_t sd2_s4;

	// c at 1.0 means theta is exactly zero
	assign theta_c = (sd1_dly.c_full || ang < 0) ? '0 : ang[30:0];
	assign pr1     = (qs_pkg::ONE_Q30 - sd1_dly.t) * theta_c;
	assign pr2     = sd1_dly.t * theta_c;

	always_ff @(posedge clk) begin
		if (en) begin
			theta_s4     <= theta_c;
			ang1_s4      <= pr1[60:30];
			ang2_s4      <= pr2[60:30];
			sd2_s4.a     <= sd1_dly.a;
			sd2_s4.b     <= sd1_dly.b;
			sd2_s4.pass  <= theta_c <= qs_pkg::THETA_EPS;
		end
	end

	// ---------------------------------------------------------------- sines and weights
	logic [30:0]    sin_th, sin1, sin2;
	logic [DS-1:0]  k1, k2;
	logic           dz;
	qs_pkg::side2_t sd2_dly;

	qs_cordic_rot u_sin_th (.clk(clk), .en(en), .ang(theta_s4), .sine(sin_th));
	qs_cordic_rot u_sin1   (.clk(clk), .en(en), .ang(ang1_s4),  .sine(sin1));
	qs_cordic_rot u_sin2   (.clk(clk), .en(en), .ang(ang2_s4),  .sine(sin2));

	qs_div u_div1 (.clk(clk), .en(en), .num(sin1), .den(sin_th), .quo(k1));
	qs_div u_div2 (.clk(clk), .en(en), .num(sin2), .den(sin_th), .quo(k2));

	// zero sine of theta falls back to the first quaternion
	qs_delay #(.W(1), .N(DS)) u_dz_dly (
		.clk  (clk),
		.en   (en),
		.din  (sin_th == '0),
		.dout (dz)
	);

	qs_delay #(.W($bits(qs_pkg::side2_t)), .N(CS + DS)) u_sd2_dly (
		.clk  (clk),
		.en   (en),
		.din  (sd2_s4),
		.dout (sd2_dly)
	);

	// ---------------------------------------------------------------- s5..s8: blend
	logic signed [41:0] pal_s5 [4], pah_s5 [4], pbl_s5 [4], pbh_s5 [4];
	logic signed [16:0] a_s5 [4], a_s6 [4], a_s7 [4];
	logic               pass_s5, pass_s6, pass_s7;
	logic signed [65:0] pa_s6 [4], pb_s6 [4];
	logic signed [65:0] acc_s7 [4];
	logic        [15:0] out_s8 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			// 48-bit weights split in two halves per multiply
			for (int i = 0; i < 4; i++) begin
				pal_s5[i] <= $signed(sd2_dly.a[i]) * $signed({1'b0, k1[KS-1:0]});
				pah_s5[i] <= $signed(sd2_dly.a[i]) * $signed({1'b0, k1[DS-1:KS]});
				pbl_s5[i] <= $signed(17'($signed(sd2_dly.b[i]))) * $signed({1'b0, k2[KS-1:0]});
				pbh_s5[i] <= $signed(17'($signed(sd2_dly.b[i]))) * $signed({1'b0, k2[DS-1:KS]});
				a_s5[i]   <= $signed(sd2_dly.a[i]);
			end
			pass_s5 <= sd2_dly.pass || dz;

			for (int i = 0; i < 4; i++) begin
				pa_s6[i] <= (66'(pah_s5[i]) <<< KS) + 66'(pal_s5[i]);
				pb_s6[i] <= (66'(pbh_s5[i]) <<< KS) + 66'(pbl_s5[i]);
				a_s6[i]  <= a_s5[i];
			end
			pass_s6 <= pass_s5;

			for (int i = 0; i < 4; i++) begin
				acc_s7[i] <= pa_s6[i] + pb_s6[i] + (66'sd1 <<< 29);
				a_s7[i]   <= a_s6[i];
			end
			pass_s7 <= pass_s6;

			for (int i = 0; i < 4; i++)
				out_s8[i] <= pass_s7 ? qs_pkg::sat16(36'(a_s7[i]))
					: qs_pkg::sat16(acc_s7[i][65:30]);
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			m_tdata[16*i +: 16] = out_s8[i];
	end

	// ---------------------------------------------------------------- checks
	`QS_ASSERT_IMPLY(a_hold_only_on_stall, !s_tready, m_tvalid && !m_tready)
	`QS_ASSERT_NEXT(a_first_stage_load, s_tready, vld_s[0] == $past(s_tvalid))

endmodule

[design/qs_delay.sv]
// ----------------------------------------------------------------------------
// qs_delay
// Enabled shift line that walks side data alongside the compute pipes.
// ----------------------------------------------------------------------------
module qs_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] pipe_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= din;
			for (int i = 1; i < N; i++)
				pipe_s[i] <= pipe_s[i-1];
		end
	end

	assign dout = pipe_s[N-1];

endmodule

[design/qs_sqrt.sv]
// ----------------------------------------------------------------------------
// qs_sqrt
// Pipelined integer square root, one root bit per stage (floor).
// ----------------------------------------------------------------------------
module qs_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [60:0] v,
	output logic [30:0] root
);

	localparam int N = qs_pkg::SQRT_STEPS;

	logic [60:0] rem_s  [N-1];
	logic [30:0] root_s [N];

	for (genvar g = 0; g < N; g++) begin : g_st
		localparam int K = N - 1 - g;
		logic [60:0] rem_in;
		logic [30:0] root_in;
		logic [62:0] trial;
		logic        ge;

		if (g == 0) begin : g_first
			assign rem_in  = v;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
		end

		// (R + 2^K)^2 - R^2 = R*2^(K+1) + 2^(2K)
		assign trial = ({32'b0, root_in} << (K + 1)) + (63'd1 << (2 * K));
		assign ge    = {2'b0, rem_in} >= trial;

		always_ff @(posedge clk) begin
			if (en)
				root_s[g] <= ge ? (root_in | (31'd1 << K)) : root_in;
		end

		if (g < N - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en)
					rem_s[g] <= ge ? (rem_in - trial[60:0]) : rem_in;
			end
		end
	end

	assign root = root_s[N-1];

endmodule

[design/qs_cordic_vec.sv]
// ----------------------------------------------------------------------------
// qs_cordic_vec
// Pipelined CORDIC vectoring: angle of (x, y) in the first quadrant, Q30.
// ----------------------------------------------------------------------------
module qs_cordic_vec (
	input  logic               clk,
	input  logic               en,
	input  logic        [30:0] x0,
	input  logic        [30:0] y0,
	output logic signed [33:0] ang
);

	localparam int N = qs_pkg::CORDIC_STEPS;

	logic signed [33:0] x_s [N-1];
	logic signed [33:0] y_s [N-1];
	logic signed [33:0] z_s [N];

	for (genvar g = 0; g < N; g++) begin : g_st
		logic signed [33:0] xi, yi, zi, atn;

		if (g == 0) begin : g_first
			assign xi = signed'({3'b0, x0});
			assign yi = signed'({3'b0, y0});
			assign zi = '0;
		end else begin : g_next
			assign xi = x_s[g-1];
			assign yi = y_s[g-1];
			assign zi = z_s[g-1];
		end

		assign atn = signed'({4'b0, qs_pkg::ATAN_TAB[g]});

		always_ff @(posedge clk) begin
			if (en)
				z_s[g] <= (yi > 0) ? (zi + atn) : (zi - atn);
		end

		if (g < N - 1) begin : g_xy
			always_ff @(posedge clk) begin
				if (en) begin
					if (yi > 0) begin
						x_s[g] <= xi + (yi >>> g);
						y_s[g] <= yi - (xi >>> g);
					end else begin
						x_s[g] <= xi - (yi >>> g);
						y_s[g] <= yi + (xi >>> g);
					end
				end
			end
		end
	end

	assign ang = z_s[N-1];

endmodule

[design/qs_cordic_rot.sv]
// ----------------------------------------------------------------------------
// qs_cordic_rot
// Pipelined CORDIC rotation: sine of a Q30 angle, limited to 0..1.0.
// ----------------------------------------------------------------------------
module qs_cordic_rot (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] ang,
	output logic [30:0] sine
);

	localparam int N = qs_pkg::CORDIC_STEPS;

	logic signed [33:0] x_s [N-1];
	logic signed [33:0] y_s [N];
	logic signed [33:0] z_s [N-1];
	logic signed [33:0] y_end;

	for (genvar g = 0; g < N; g++) begin : g_st
		logic signed [33:0] xi, yi, zi, atn;

		if (g == 0) begin : g_first
			assign xi = signed'({3'b0, qs_pkg::CORDIC_GAIN_INV});
			assign yi = '0;
			assign zi = signed'({3'b0, ang});
		end else begin : g_next
			assign xi = x_s[g-1];
			assign yi = y_s[g-1];
			assign zi = z_s[g-1];
		end

		assign atn = signed'({4'b0, qs_pkg::ATAN_TAB[g]});

		always_ff @(posedge clk) begin
			if (en)
				y_s[g] <= (zi >= 0) ? (yi + (xi >>> g)) : (yi - (xi >>> g));
		end

		if (g < N - 1) begin : g_xz
			always_ff @(posedge clk) begin
				if (en) begin
					if (zi >= 0) begin
						x_s[g] <= xi - (yi >>> g);
						z_s[g] <= zi - atn;
					end else begin
						x_s[g] <= xi + (yi >>> g);
						z_s[g] <= zi + atn;
					end
				end
			end
		end
	end

	assign y_end = y_s[N-1];

	always_comb begin
		if (y_end < 0)
			sine = '0;
		else if (y_end > signed'({3'b0, qs_pkg::ONE_Q30}))
			sine = qs_pkg::ONE_Q30;
		else
			sine = y_end[30:0];
	end

endmodule

[design/qs_div.sv]
// ----------------------------------------------------------------------------
// qs_div
// Pipelined restoring divider: floor(num * 2^30 / den), one quotient bit
// per stage. Divisor is at least 2^13 whenever the quotient is used.
// ----------------------------------------------------------------------------
module qs_div (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] num,
	input  logic [30:0] den,
	output logic [qs_pkg::DIV_STEPS-1:0] quo
);

	localparam int N = qs_pkg::DIV_STEPS;

	logic [60:0]  dvd;
	logic [30:0]  rem_s [N-1];
	logic [30:0]  den_s [N-1];
	logic [N-1:0] low_s [N];

	assign dvd = {num, {qs_pkg::QBITS{1'b0}}};

	for (genvar g = 0; g < N; g++) begin : g_st
		logic [30:0]  rem_in, den_in;
		logic [N-1:0] low_in;
		logic [31:0]  sh, diff;
		logic         ge;

		if (g == 0) begin : g_first
			assign rem_in = 31'(dvd >> N);
			assign low_in = dvd[N-1:0];
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign low_in = low_s[g-1];
			assign den_in = den_s[g-1];
		end

		// dividend bits shift out of the top of low, quotient bits in at the bottom
		assign sh   = {rem_in, low_in[N-1]};
		assign diff = sh - {1'b0, den_in};
		assign ge   = sh >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en)
				low_s[g] <= {low_in[N-2:0], ge};
		end

		if (g < N - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= ge ? diff[30:0] : sh[30:0];
					den_s[g] <= den_in;
				end
			end
		end
	end

	assign quo = low_s[N-1];

endmodule
